// ----- sv/sctc_pkg.sv -----
// ----------------------------------------------------------------------------
// sctc_pkg: shared types and constants of the scan cycle timing compensator
// Widths, reset values, register indexes, the state and result records and
// the clamp helper used by the datapath.
// ----------------------------------------------------------------------------
package sctc_pkg;

  // Time arithmetic width; stored times are one bit narrower (non-negative)
  localparam int TIME_BITS  = 64;
  localparam int FIELD_W    = TIME_BITS - 1;
  localparam int CNT_BITS   = 32;
  localparam int PERIOD_W   = 30;
  localparam int INTERVAL_W = 10;
  localparam int SLEEP_W    = 30;
  localparam int STEP_W     = PERIOD_W + INTERVAL_W;
  // Wide signed width used for exact sums before clamping
  localparam int WIDE_W     = TIME_BITS + 2;

  localparam logic [PERIOD_W-1:0]   PERIOD_RST   = PERIOD_W'(20000000);
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = INTERVAL_W'(10);

  // Saturation bounds
  localparam logic [FIELD_W-1:0] T_MASK = {FIELD_W{1'b1}};
  localparam logic [FIELD_W-1:0] D_MAX  = {1'b0, {(FIELD_W-1){1'b1}}};
  localparam logic [FIELD_W-1:0] D_MIN  = {1'b1, {(FIELD_W-1){1'b0}}};
  localparam logic [SLEEP_W-1:0] SLEEP_MAX = {SLEEP_W{1'b1}};

  // Register indexes on the configuration port
  typedef enum logic {
    REG_PERIOD   = 1'b0,
    REG_INTERVAL = 1'b1
  } reg_idx_e;

  // Compensator state; signed members are kept as raw two's complement bits
  typedef struct packed {
    logic                  first;
    logic [FIELD_W-1:0]    base;
    logic [FIELD_W-1:0]    prev_end;
    logic [FIELD_W-1:0]    debt;
    logic [FIELD_W-1:0]    drift;
    logic [FIELD_W-1:0]    expected;
    logic [FIELD_W-1:0]    total;
    logic [CNT_BITS-1:0]   count;
    logic [INTERVAL_W-1:0] phase;
    logic                  err;
  } state_t;

  // One result transaction
  typedef struct packed {
    logic [SLEEP_W-1:0]  sleep;
    logic [FIELD_W-1:0]  delay;
    logic [FIELD_W-1:0]  latency;
    logic [FIELD_W-1:0]  total;
    logic                overrun;
    logic                err;
    logic [CNT_BITS-1:0] index;
  } result_t;

  // Clamp an exact wide value into the signed debt/drift range
  function automatic logic [FIELD_W-1:0] clamp_d(input logic signed [WIDE_W-1:0] v);
    logic [FIELD_W-1:0] r;
    if (v > $signed({{(WIDE_W-FIELD_W){1'b0}}, D_MAX})) begin
      r = D_MAX;
    end else if (v < $signed({{(WIDE_W-FIELD_W){1'b1}}, D_MIN})) begin
      r = D_MIN;
    end else begin
      r = v[FIELD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/sctc_calc.sv -----
// ----------------------------------------------------------------------------
// sctc_calc: per-scan compensation datapath
// Computes the next compensator state and the result transaction for one scan
// from the current state, the job times and the configuration.
// ----------------------------------------------------------------------------
module sctc_calc
  import sctc_pkg::*;
(
  input  state_t                st_i,
  input  logic [FIELD_W-1:0]    start_i,
  input  logic [FIELD_W-1:0]    end_i,
  input  logic [PERIOD_W-1:0]   period_i,
  input  logic [INTERVAL_W-1:0] interval_i,
  input  logic [STEP_W-1:0]     step_i,
  output state_t                st_o,
  output result_t               res_o
);

  logic [FIELD_W-1:0]          base;
  logic [FIELD_W-1:0]          prev;
  logic signed [TIME_BITS-1:0] job;
  logic signed [TIME_BITS-1:0] elapsed;
  logic signed [TIME_BITS-1:0] period_s;
  logic signed [TIME_BITS-1:0] rel;
  logic signed [TIME_BITS:0]   slack;
  logic signed [FIELD_W-1:0]   debt;
  logic signed [FIELD_W-1:0]   drift;
  logic                        over;
  logic [FIELD_W-1:0]          debt_n;
  logic [FIELD_W-1:0]          drift_n;
  logic [SLEEP_W-1:0]          sleep;
  logic [TIME_BITS-1:0]        exp_sum;
  logic [FIELD_W-1:0]          exp_n;
  logic signed [WIDE_W-1:0]    tot;
  logic [FIELD_W-1:0]          total_n;
  logic [INTERVAL_W-1:0]       ph_inc;

  always_comb begin
    // First scan takes its start as time base and previous end
    base = st_i.first ? start_i : st_i.base;
    prev = st_i.first ? start_i : st_i.prev_end;

    job      = {1'b0, end_i} - {1'b0, start_i};
    elapsed  = {1'b0, end_i} - {1'b0, prev};
    rel      = {1'b0, end_i} - {1'b0, base};
    period_s = $signed(TIME_BITS'(period_i));
    debt     = $signed(st_i.debt);
    drift    = $signed(st_i.drift);

    over  = job >= period_s;
    slack = (TIME_BITS+1)'(period_s) - (TIME_BITS+1)'(job);

    // Pay off debt or drift (drift on a tie) with the slack, or sleep; overrun adds to scan delay
    debt_n  = st_i.debt;
    drift_n = st_i.drift;
    sleep   = '0;
    if (!over) begin
      if (debt > drift) begin
        if (debt > 0) begin
          debt_n = clamp_d(WIDE_W'(debt) - WIDE_W'(slack));
        end else if (slack > $signed((TIME_BITS+1)'(SLEEP_MAX))) begin
          sleep = SLEEP_MAX;
        end else begin
          sleep = slack[SLEEP_W-1:0];
        end
      end else begin
        if (drift > 0) begin
          drift_n = clamp_d(WIDE_W'(drift) - WIDE_W'(slack));
        end else if (slack > $signed((TIME_BITS+1)'(SLEEP_MAX))) begin
          sleep = SLEEP_MAX;
        end else begin
          sleep = slack[SLEEP_W-1:0];
        end
      end
    end else begin
      debt_n = clamp_d(WIDE_W'(debt) + WIDE_W'(job) - WIDE_W'(period_s));
    end

    // Rollup: grow expected time and recompute latency against it
    exp_sum = {1'b0, st_i.expected} + TIME_BITS'(step_i);
    exp_n   = st_i.expected;
    if (st_i.phase == '0) begin
      exp_n   = exp_sum[TIME_BITS-1] ? T_MASK : exp_sum[FIELD_W-1:0];
      drift_n = clamp_d(WIDE_W'(rel) - WIDE_W'($signed({1'b0, exp_n})));
    end

    // Elapsed total saturates into [0, T_MASK]
    tot = WIDE_W'($signed({1'b0, st_i.total})) + WIDE_W'(elapsed);
    if (tot < 0) begin
      total_n = '0;
    end else if (tot > $signed({{(WIDE_W-FIELD_W){1'b0}}, T_MASK})) begin
      total_n = T_MASK;
    end else begin
      total_n = tot[FIELD_W-1:0];
    end

    ph_inc = st_i.phase + INTERVAL_W'(1);

    st_o.first    = 1'b0;
    st_o.base     = base;
    st_o.prev_end = end_i;
    st_o.debt     = debt_n;
    st_o.drift    = drift_n;
    st_o.expected = exp_n;
    st_o.total    = total_n;
    st_o.count    = st_i.count + CNT_BITS'(1);
    st_o.phase    = (ph_inc >= interval_i) ? '0 : ph_inc;
    st_o.err      = st_i.err | over | job[TIME_BITS-1] | elapsed[TIME_BITS-1];

    res_o.sleep   = sleep;
    res_o.delay   = debt_n;
    res_o.latency = drift_n;
    res_o.total   = total_n;
    res_o.overrun = over;
    res_o.err     = st_o.err;
    res_o.index   = st_i.count;
  end

endmodule

// ----- sv/scan_cycle_timing_compensator_unit.sv -----
// ----------------------------------------------------------------------------
// scan_cycle_timing_compensator_unit: scan cycle timing compensator top level
// Input register, compensation datapath, result register and the APB
// configuration registers.
// ----------------------------------------------------------------------------
// One transaction in is one finished scan (job start and end, ns); it yields
// one result transaction, which passes the input register and then the result
// register. A new scan is taken every cycle while the output is not stalled:
// the compensator state (debt, drift, expected time, totals) is updated in a
// single pass through the datapath between the input register and the result
// register, and the result register lets the next scan enter while a result
// waits. Registers: scan_period_ns at address 0x0, rollup_interval at 0x4;
// write them only while no scan is in flight.
module scan_cycle_timing_compensator_unit
  import sctc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // scan input
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [FIELD_W-1:0]  job_start_ns_i,
  input  logic [FIELD_W-1:0]  job_end_ns_i,
  // result output
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [SLEEP_W-1:0]  sleep_ns_o,
  output logic [FIELD_W-1:0]  scan_delay_ns_o,
  output logic [FIELD_W-1:0]  latency_ns_o,
  output logic [FIELD_W-1:0]  elapsed_total_ns_o,
  output logic                overrun_o,
  output logic                error_flag_o,
  output logic [CNT_BITS-1:0] scan_index_o,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [PERIOD_W-1:0]   period_q;
  logic [INTERVAL_W-1:0] interval_q;
  logic [STEP_W-1:0]     step_q;
  logic                  cfg_wr;
  reg_idx_e              cfg_idx;

  logic                  s1_valid_q;
  logic [FIELD_W-1:0]    start_q;
  logic [FIELD_W-1:0]    end_q;
  logic                  out_valid_q;
  result_t               res_q;
  result_t               res_d;
  state_t                st_q;
  state_t                st_d;
  logic                  out_free;
  logic                  s1_fire;
  logic                  in_fire;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[2]);

  always_comb begin
    unique case (cfg_idx)
      REG_PERIOD:   prdata = 32'(period_q);
      REG_INTERVAL: prdata = 32'(interval_q);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= PERIOD_RST;
      interval_q <= INTERVAL_RST;
      step_q     <= STEP_W'(PERIOD_RST) * STEP_W'(INTERVAL_RST);
    end else begin
      if (cfg_wr && cfg_idx == REG_PERIOD) begin
        period_q <= pwdata[PERIOD_W-1:0];
      end
      if (cfg_wr && cfg_idx == REG_INTERVAL) begin
        interval_q <= pwdata[INTERVAL_W-1:0];
      end
      // Rollup step follows the registers in the next cycle
      step_q <= STEP_W'(period_q) * STEP_W'(interval_q);
    end
  end

  // Handshake: stage 1 advances whenever the result register is free
  assign out_free   = ~out_valid_q | out_ready_i;
  assign s1_fire    = s1_valid_q & out_free;
  assign in_ready_o = ~s1_valid_q | out_free;
  assign in_fire    = in_valid_i & in_ready_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      start_q <= job_start_ns_i;
      end_q   <= job_end_ns_i;
    end
  end

  // Compensation datapath
  sctc_calc u_calc (
    .st_i       (st_q),
    .start_i    (start_q),
    .end_i      (end_q),
    .period_i   (period_q),
    .interval_i (interval_q),
    .step_i     (step_q),
    .st_o       (st_d),
    .res_o      (res_d)
  );

  // Compensator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{first: 1'b1, default: '0};
    end else if (s1_fire) begin
      st_q <= st_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign sleep_ns_o         = res_q.sleep;
  assign scan_delay_ns_o    = res_q.delay;
  assign latency_ns_o       = res_q.latency;
  assign elapsed_total_ns_o = res_q.total;
  assign overrun_o          = res_q.overrun;
  assign error_flag_o       = res_q.err;
  assign scan_index_o       = res_q.index;

  // Assertions
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.err |=> st_q.err)
    else $error("sticky error cleared");

  a_overrun_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.overrun |-> res_q.err)
    else $error("overrun without error flag");

  a_overrun_nosleep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.overrun |-> res_q.sleep == '0)
    else $error("sleep reported on overrun");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> st_q.count == $past(st_q.count) + CNT_BITS'(1))
    else $error("scan count did not advance by one");

  a_first_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> !st_q.first)
    else $error("first-scan flag still set after a scan");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: scan cycle timing compensator testbench
// Feeds finished scans (job start/end times) through the valid/ready input,
// predicts sleep, debt, drift, totals and flags for each scan with a
// cycle-free model kept inside this module, and compares every result
// transaction field by field. Configuration goes through the APB port
// between phases, while nothing is in flight.
// ----------------------------------------------------------------------------
module tb_top;
  import sctc_pkg::*;

  localparam int          CYCLE_LIMIT = 1000000;
  localparam longint      SPAN_MAX    = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam longint      SPAN_MIN    = -SPAN_MAX - 1;
  localparam longint      TIME_TOP    = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint      SLEEP_TOP   = 64'sd1073741823;
  localparam logic [62:0] TOP_NS      = '1;
  // time base of the directed scans, bit 62 set so that drift can clamp low
  localparam logic [62:0] BASE_NS     = 63'h4000_0000_0000_3039;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [FIELD_W-1:0]  job_start_ns_i;
  logic [FIELD_W-1:0]  job_end_ns_i;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [SLEEP_W-1:0]  sleep_ns_o;
  logic [FIELD_W-1:0]  scan_delay_ns_o;
  logic [FIELD_W-1:0]  latency_ns_o;
  logic [FIELD_W-1:0]  elapsed_total_ns_o;
  logic                overrun_o;
  logic                error_flag_o;
  logic [CNT_BITS-1:0] scan_index_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  scan_cycle_timing_compensator_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .job_start_ns_i     (job_start_ns_i),
    .job_end_ns_i       (job_end_ns_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .sleep_ns_o         (sleep_ns_o),
    .scan_delay_ns_o    (scan_delay_ns_o),
    .latency_ns_o       (latency_ns_o),
    .elapsed_total_ns_o (elapsed_total_ns_o),
    .overrun_o          (overrun_o),
    .error_flag_o       (error_flag_o),
    .scan_index_o       (scan_index_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Compensator model state and configuration, reset values
  bit          sc_first    = 1'b1;
  longint      sc_base     = 0;
  longint      sc_prev_end = 0;
  longint      sc_debt     = 0;
  longint      sc_drift    = 0;
  longint      sc_expected = 0;
  longint      sc_total    = 0;
  int unsigned sc_count    = 0;
  logic [9:0]  sc_phase    = '0;
  bit          sc_err      = 1'b0;
  longint      cfg_period   = 20000000;
  longint      cfg_interval = 10;

  result_t     pending_timing[$];
  int          mismatches = 0;
  int          cycle_cnt  = 0;

  // Stimulus shaping
  logic [62:0] now_ns     = '0;
  longint      last_sleep = 0;
  bit          idle_on    = 1'b1;
  int          stall_pct  = 25;
  int          stall_left = 0;

  function automatic logic signed [65:0] wide(input longint v);
    return 66'(v);
  endfunction

  // clamp into the signed debt/drift range
  function automatic longint to_span(input logic signed [65:0] v);
    if (v > wide(SPAN_MAX)) return SPAN_MAX;
    if (v < wide(SPAN_MIN)) return SPAN_MIN;
    return v[63:0];
  endfunction

  function automatic logic [SLEEP_W-1:0] cap_sleep(input logic signed [65:0] v);
    if (v > wide(SLEEP_TOP)) return '1;
    return v[SLEEP_W-1:0];
  endfunction

  // Predict one scan's result and advance the model state
  function automatic result_t compensate_scan(input logic [62:0] st, input logic [62:0] en);
    result_t                r;
    longint                 job;
    longint                 lapse;
    logic signed [65:0]     slack;
    logic signed [65:0]     acc;
    logic [SLEEP_W-1:0]     nap;
    bit                     over;
    if (sc_first) begin
      sc_base     = longint'({1'b0, st});
      sc_prev_end = longint'({1'b0, st});
      sc_first    = 1'b0;
    end
    job   = longint'({1'b0, en}) - longint'({1'b0, st});
    lapse = longint'({1'b0, en}) - sc_prev_end;
    if (job < 0 || lapse < 0) sc_err = 1'b1;
    over = (job >= cfg_period);
    nap  = '0;
    // slack pays the larger of debt and drift while it is positive
    if (!over) begin
      slack = wide(cfg_period) - wide(job);
      if (sc_debt > sc_drift) begin
        if (sc_debt > 0) sc_debt = to_span(wide(sc_debt) - slack);
        else nap = cap_sleep(slack);
      end else if (sc_drift > 0) begin
        sc_drift = to_span(wide(sc_drift) - slack);
      end else begin
        nap = cap_sleep(slack);
      end
    end else begin
      sc_err  = 1'b1;
      sc_debt = to_span(wide(sc_debt) + wide(job) - wide(cfg_period));
    end
    // rollup: expected time grows, drift recomputed against real time
    if (sc_phase == 0) begin
      acc = wide(sc_expected) + wide(cfg_period * cfg_interval);
      sc_expected = (acc > wide(TIME_TOP)) ? TIME_TOP : acc[63:0];
      sc_drift = to_span(wide(longint'({1'b0, en}) - sc_base) - wide(sc_expected));
    end
    acc = wide(sc_total) + wide(lapse);
    if (acc < 0) sc_total = 0;
    else if (acc > wide(TIME_TOP)) sc_total = TIME_TOP;
    else sc_total = acc[63:0];
    r.sleep   = nap;
    r.delay   = sc_debt[62:0];
    r.latency = sc_drift[62:0];
    r.total   = sc_total[62:0];
    r.overrun = over;
    r.err     = sc_err;
    r.index   = sc_count;
    sc_prev_end = longint'({1'b0, en});
    sc_count    = sc_count + 1;
    sc_phase    = sc_phase + 1'b1;
    if (sc_phase >= cfg_interval) sc_phase = '0;
    return r;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [62:0] rand_ns();
    logic [63:0] t;
    int          r;
    r = $urandom_range(0, 7);
    t = {$urandom, $urandom};
    if (r == 0) return '0;
    if (r == 1) return TOP_NS;
    return t[62:0];
  endfunction

  function automatic longint pick_job(input longint p);
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return (p * $urandom_range(0, 1000)) / 1100;
    if (r < 78) return p + longint'($urandom_range(0, 32'(p)));
    if (r < 84) return p;
    if (r < 90) return (p > 0) ? p - 1 : 0;
    if (r < 95) return 0;
    return 3 * p + longint'($urandom);
  endfunction

  // Result checking and output back-pressure
  function automatic void check_field(input string nm, input int unsigned idx,
                                      input logic [62:0] want, input logic [62:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: scan %0d %s mismatch, expected %h, actual %h",
               $time, idx, nm, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_timing.size() == 0) begin
        mismatches++;
        $display("%0t: result transaction with none expected, expected nothing, actual index %0d",
                 $time, scan_index_o);
      end else begin
        want = pending_timing.pop_front();
        check_field("sleep_ns", want.index, 63'(want.sleep), 63'(sleep_ns_o));
        check_field("scan_delay_ns", want.index, want.delay, scan_delay_ns_o);
        check_field("latency_ns", want.index, want.latency, latency_ns_o);
        check_field("elapsed_total_ns", want.index, want.total, elapsed_total_ns_o);
        check_field("overrun", want.index, 63'(want.overrun), 63'(overrun_o));
        check_field("error_flag", want.index, 63'(want.err), 63'(error_flag_o));
        check_field("scan_index", want.index, 63'(want.index), 63'(scan_index_o));
      end
    end
    if (stall_pct == 0) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 99) < stall_pct) stall_left = pick_gap();
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // One scan transaction; prediction at acceptance
  task automatic send_scan(input logic [62:0] st, input logic [62:0] en);
    result_t r;
    int      gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    job_start_ns_i <= st;
    job_end_ns_i   <= en;
    do @(posedge clk_i); while (!in_ready_o);
    r = compensate_scan(st, en);
    pending_timing.push_back(r);
    last_sleep = longint'(r.sleep);
  endtask

  // Stop sending and wait until every result is in
  task automatic settle_results();
    in_valid_i <= 1'b0;
    while (pending_timing.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write: setup, then access until pready
  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_PERIOD) cfg_period = longint'(val[PERIOD_W-1:0]);
    else cfg_interval = longint'(val[INTERVAL_W-1:0]);
    @(posedge clk_i);
  endtask

  // Next scan: mostly a scheduler following the predicted sleep, some
  // rewound or reversed scans, some noise
  task automatic make_scan(output logic [62:0] st, output logic [62:0] en);
    int     pick;
    longint gap;
    longint job;
    pick = $urandom_range(0, 99);
    gap  = last_sleep;
    if ($urandom_range(0, 3) == 0) gap += $urandom_range(0, 1000);
    job  = pick_job(cfg_period);
    if (pick < 85) begin
      st = 63'(now_ns + gap);
      en = 63'(st + job);
      now_ns = en;
    end else if (pick < 90) begin
      st = now_ns - $urandom_range(1, 100000);
      en = 63'(st + job);
      now_ns = en;
    end else if (pick < 94) begin
      en = 63'(now_ns + gap);
      st = en + $urandom_range(1, 32'hFFFF_FFFF);
      now_ns = st;
    end else begin
      st = rand_ns();
      en = $urandom_range(0, 1) ? rand_ns() : 63'(st + job);
    end
  endtask

  task automatic run_scans(input int n);
    logic [62:0] st;
    logic [62:0] en;
    repeat (n) begin
      make_scan(st, en);
      send_scan(st, en);
    end
  endtask

  // New setting: drain, write both registers, line real time up with the
  // expected time base
  task automatic run_setting(input logic [31:0] period, input logic [31:0] interval,
                             input int n);
    settle_results();
    write_reg(REG_PERIOD, period);
    write_reg(REG_INTERVAL, interval);
    now_ns     = 63'(sc_base + sc_expected);
    last_sleep = 0;
    run_scans(n);
  endtask

  // Reset settings: first scan, period boundary, long sleep, negative
  // job and elapsed, debt and drift saturation
  task automatic test_directed_defaults();
    send_scan(BASE_NS, BASE_NS + 63'd5_000_000);
    send_scan(BASE_NS + 63'd20_000_000, BASE_NS + 63'd40_000_000);
    send_scan(BASE_NS + 63'd40_000_001, BASE_NS + 63'd60_000_000);
    send_scan(BASE_NS + 63'd3_000_000_000, BASE_NS + 63'd60_001_000);
    send_scan(BASE_NS + 63'd50_000_000, BASE_NS + 63'd55_000_000);
    send_scan('0, TOP_NS);
    send_scan(TOP_NS, TOP_NS);
    send_scan(TOP_NS, '0);
    send_scan('0, '0);
    send_scan(63'd1, '0);
    send_scan('0, '0);
    send_scan(TOP_NS, TOP_NS);
  endtask

  // Zero period and zero interval: rollup every scan
  task automatic test_zero_period_interval();
    settle_results();
    write_reg(REG_PERIOD, 32'd0);
    write_reg(REG_INTERVAL, 32'd0);
    send_scan(63'd5, 63'd5);
    send_scan(63'd5, 63'd3);
    send_scan(TOP_NS, TOP_NS);
    send_scan('0, TOP_NS);
    send_scan(BASE_NS, BASE_NS);
    send_scan(63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555);
  endtask

  // Default settings, with a full pause halfway
  task automatic test_default_random();
    run_setting(32'd20_000_000, 32'd10, 120);
    settle_results();
    run_scans(130);
  endtask

  task automatic test_setting_extremes();
    run_setting(32'd1, 32'd1, 150);
    run_setting(32'd1_000_000_000, 32'd1000, 150);
    run_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 150);
    run_setting(32'd0, 32'd0, 100);
  endtask

  // Interval lowered below the running phase, then to zero
  task automatic test_interval_shrink();
    run_setting(32'd1000, 32'd50, 37);
    settle_results();
    write_reg(REG_INTERVAL, 32'd3);
    run_scans(40);
    settle_results();
    write_reg(REG_INTERVAL, 32'd0);
    run_scans(40);
  endtask

  // Back-to-back transactions, then heavy output stalls
  task automatic test_handshake_bursts();
    idle_on   = 1'b0;
    stall_pct = 0;
    run_setting(32'd500, 32'd4, 100);
    stall_pct = 80;
    run_scans(100);
    idle_on   = 1'b1;
    stall_pct = 25;
  endtask

  task automatic test_full_random();
    run_setting($urandom, $urandom, 25);
    run_setting($urandom_range(0, 1000), $urandom_range(0, 20), 25);
    run_setting($urandom, $urandom, 25);
    run_setting($urandom_range(0, 100000), $urandom_range(1, 1023), 25);
  endtask

  initial begin
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    job_start_ns_i <= '0;
    job_end_ns_i   <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_defaults();
    test_zero_period_interval();
    test_default_random();
    test_setting_extremes();
    test_interval_shrink();
    test_handshake_bursts();
    test_full_random();

    settle_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- scan_cycle_timing_compensator_unit.f -----
sv/sctc_pkg.sv
sv/sctc_calc.sv
sv/scan_cycle_timing_compensator_unit.sv
tb/tb_top.sv
